// ----- rtl/cbrg_pkg.sv -----
`timescale 1ns / 1ps

package cbrg_pkg;

    // fixed field widths of the channels
    localparam int unsigned REG_W     = 13;
    localparam int unsigned SRC_ROW_W = 13;

    // action codes carried on the input channel
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GFX_ENABLE   = 2'd2;

    typedef enum logic [2:0] {
        ST_ROW      = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_REJECTED = 3'd3,
        ST_IDLE     = 3'd4
    } status_t;

    typedef struct packed {
        logic        action;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [11:0] src_x;
        logic [11:0] src_y;
        logic [12:0] copy_width;
        logic [12:0] copy_height;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] dest_offset;
        logic [23:0] src_offset;
        logic [8:0]  row_length;
        logic        last_row;
    } out_item_t;

endpackage

// ----- rtl/cbrg_in_if.sv -----
`timescale 1ns / 1ps

interface cbrg_in_if
    import cbrg_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/cbrg_out_if.sv -----
`timescale 1ns / 1ps

interface cbrg_out_if
    import cbrg_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/cbrg_clip.sv -----
`timescale 1ns / 1ps

// clips the requested rectangle to the image, then to the screen
module cbrg_clip
    import cbrg_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 200,
    parameter int unsigned DIM_W         = 13,
    parameter int unsigned CW            = 9,
    parameter int unsigned RW            = 8
) (
    input  in_item_t         item,
    input  logic [DIM_W-1:0] cap_w,
    input  logic [DIM_W-1:0] cap_h,
    output logic [CW-1:0]    clip_w,
    output logic [RW-1:0]    clip_h
);

    logic [12:0] cap_w13, cap_h13;
    logic [12:0] sx13, sy13;
    logic [12:0] room_ix, room_iy;
    logic [12:0] w_img, h_img;
    logic [15:0] room_sx, room_sy;
    logic [15:0] w16, h16;
    logic [15:0] w_scr, h_scr;

    assign cap_w13 = 13'(cap_w);
    assign cap_h13 = 13'(cap_h);
    assign sx13    = {1'b0, item.src_x};
    assign sy13    = {1'b0, item.src_y};
    assign room_ix = cap_w13 - sx13;
    assign room_iy = cap_h13 - sy13;

    // image clip
    always_comb
    begin
        if (sx13 >= cap_w13)
            w_img = '0;
        else if (item.copy_width > room_ix)
            w_img = room_ix;
        else
            w_img = item.copy_width;

        if (sy13 >= cap_h13)
            h_img = '0;
        else if (item.copy_height > room_iy)
            h_img = room_iy;
        else
            h_img = item.copy_height;
    end

    assign room_sx = 16'(SCREEN_WIDTH) - item.dest_x;
    assign room_sy = 16'(SCREEN_HEIGHT) - item.dest_y;
    assign w16     = {3'd0, w_img};
    assign h16     = {3'd0, h_img};

    // screen clip
    always_comb
    begin
        if (item.dest_x >= 16'(SCREEN_WIDTH))
            w_scr = '0;
        else if (w16 > room_sx)
            w_scr = room_sx;
        else
            w_scr = w16;

        if (item.dest_y >= 16'(SCREEN_HEIGHT))
            h_scr = '0;
        else if (h16 > room_sy)
            h_scr = room_sy;
        else
            h_scr = h16;
    end

    assign clip_w = CW'(w_scr);
    assign clip_h = RW'(h_scr);

endmodule

// ----- rtl/clipped_blit_row_generator.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// in_ch     in   valid / ready      in_item_t: action, rectangle fields
// out_ch    out  valid / ready      out_item_t: status, offsets, length, last mark
// cfg       in   cfg_we, no ready   cfg_index selects register, cfg_data value
//
// an input transfer lands in an input register; combinational clip or
// row-offset logic (a multiply and an add per offset) fills the output register
// sustained rate is one item per clock unless out_ch stalls; out_ch.valid is registered
// a start item is clipped and, if accepted, stored in the row state, each next item reads
// that state and, while rows are pending, advances it as the item moves into the output register
// rst_n clears the control flags, the row state and the config registers
// a stalled out_ch holds both stages; in_ch.ready drops only while both are full
module clipped_blit_row_generator
    import cbrg_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 200,
    parameter int unsigned MAX_IMAGE_DIM = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    cbrg_in_if.sink           in_ch,
    cbrg_out_if.source        out_ch,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [REG_W-1:0]  cfg_data
);

    // column / length width and row width on screen
    localparam int unsigned CW  = $clog2(SCREEN_WIDTH + 1);
    localparam int unsigned RW  = $clog2(SCREEN_HEIGHT + 1);
    // width of a capped image dimension
    localparam int unsigned IW  = $clog2(MAX_IMAGE_DIM + 1);
    localparam int unsigned DW  = (IW < REG_W) ? IW : REG_W;
    localparam int unsigned DOW = RW + CW;
    localparam int unsigned SPW = SRC_ROW_W + DW;

    // configuration registers
    logic [REG_W-1:0] image_width_reg;
    logic [REG_W-1:0] image_height_reg;
    logic             gfx_en_reg;

    // input stage
    logic     s1_valid_reg;
    in_item_t item_reg;

    // output stage
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t result_next;

    // row state of the pending blit
    logic [RW-1:0]        rows_left_reg, rows_left_next;
    logic [RW-1:0]        dest_row_reg, dest_row_next;
    logic [SRC_ROW_W-1:0] src_row_reg, src_row_next;
    logic [CW-1:0]        clip_len_reg, clip_len_next;
    logic [CW-1:0]        dest_col_reg, dest_col_next;
    logic [11:0]          src_col_reg, src_col_next;

    logic          out_free;
    logic          s1_fire;
    logic [DW-1:0] cap_w, cap_h;
    logic [CW-1:0] clip_w;
    logic [RW-1:0] clip_h;
    logic [DOW-1:0] dest_prod;
    logic [SPW-1:0] src_prod;
    logic [15:0]    dest_off;
    logic [23:0]    src_off;

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= '0;
            image_height_reg <= '0;
            gfx_en_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_GFX_ENABLE:   gfx_en_reg       <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // oversized image dimensions act as the maximum
    assign cap_w = ({19'd0, image_width_reg} > 32'(MAX_IMAGE_DIM)) ?
                   DW'(MAX_IMAGE_DIM) : DW'(image_width_reg);
    assign cap_h = ({19'd0, image_height_reg} > 32'(MAX_IMAGE_DIM)) ?
                   DW'(MAX_IMAGE_DIM) : DW'(image_height_reg);

    // ---------------------------------------------------------------
    // handshake: the input stage moves whenever the output register
    // is empty or being drained this cycle
    // ---------------------------------------------------------------
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_fire     = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            item_reg <= in_ch.data;
    end

    // ---------------------------------------------------------------
    // start path: clip rectangle
    // ---------------------------------------------------------------
    cbrg_clip #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .DIM_W         (DW),
        .CW            (CW),
        .RW            (RW)
    ) u_clip (
        .item   (item_reg),
        .cap_w  (cap_w),
        .cap_h  (cap_h),
        .clip_w (clip_w),
        .clip_h (clip_h)
    );

    // ---------------------------------------------------------------
    // next path: row offsets, src offset wraps at 24 bits
    // ---------------------------------------------------------------
    assign dest_prod = DOW'(dest_row_reg) * DOW'(SCREEN_WIDTH);
    assign dest_off  = 16'(dest_prod + DOW'(dest_col_reg));
    assign src_prod  = SPW'(src_row_reg) * SPW'(cap_w);
    assign src_off   = 24'(src_prod) + 24'(src_col_reg);

    always_comb
    begin
        rows_left_next = rows_left_reg;
        dest_row_next  = dest_row_reg;
        src_row_next   = src_row_reg;
        clip_len_next  = clip_len_reg;
        dest_col_next  = dest_col_reg;
        src_col_next   = src_col_reg;

        result_next             = '0;
        result_next.status      = ST_IDLE;

        if (item_reg.action == ACT_START)
        begin
            // any start drops the rows still pending
            rows_left_next = '0;
            if (!gfx_en_reg)
                result_next.status = ST_REJECTED;
            else if (clip_w == '0 || clip_h == '0)
                result_next.status = ST_EMPTY;
            else
            begin
                rows_left_next     = clip_h;
                dest_row_next      = RW'(item_reg.dest_y);
                src_row_next       = SRC_ROW_W'(item_reg.src_y);
                clip_len_next      = clip_w;
                dest_col_next      = CW'(item_reg.dest_x);
                src_col_next       = item_reg.src_x;
                result_next.status = ST_ACCEPTED;
            end
        end
        else if (rows_left_reg != '0)
        begin
            result_next.status      = ST_ROW;
            result_next.dest_offset = dest_off;
            result_next.src_offset  = src_off;
            result_next.row_length  = 9'(clip_len_reg);
            result_next.last_row    = (rows_left_reg == RW'(1));
            rows_left_next          = rows_left_reg - RW'(1);
            dest_row_next           = dest_row_reg + RW'(1);
            src_row_next            = src_row_reg + SRC_ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_left_reg <= '0;
            dest_row_reg  <= '0;
            src_row_reg   <= '0;
            clip_len_reg  <= '0;
            dest_col_reg  <= '0;
            src_col_reg   <= '0;
        end
        else if (s1_fire)
        begin
            rows_left_reg <= rows_left_next;
            dest_row_reg  <= dest_row_next;
            src_row_reg   <= src_row_next;
            clip_len_reg  <= clip_len_next;
            dest_col_reg  <= dest_col_next;
            src_col_reg   <= src_col_next;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            out_data_reg <= result_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

`ifndef ASSERT_OFF
    // a pending blit always has a nonzero row length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rows_left_reg != '0 |-> clip_len_reg != '0)
        else $error("rows pending with zero row length");

    // the last row of a blit leaves no rows pending
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && result_next.status == ST_ROW && result_next.last_row
        |=> rows_left_reg == '0)
        else $error("rows still pending after last row");

    // a result that is no row descriptor carries zero fields
    a_non_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != ST_ROW
        |-> out_data_reg.dest_offset == '0 && out_data_reg.src_offset == '0 &&
            out_data_reg.row_length == '0 && !out_data_reg.last_row)
        else $error("non-row result with nonzero fields");

    // an item leaving the input stage always shows up at the output
    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("item lost between stages");

    // pending row count only drops by one unless a start item passed
    a_rows_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && item_reg.action == ACT_NEXT && rows_left_reg != '0
        |=> rows_left_reg == $past(rows_left_reg) - RW'(1))
        else $error("row count stepped wrongly");
`endif

endmodule

// ----- tb/clipped_blit_row_generator_test.sv -----
`timescale 1ns / 1ps

module clipped_blit_row_generator_test;
    import cbrg_pkg::*;

    // screen geometry and image cap of the block at default parameters
    localparam int unsigned SCREEN_W  = 320;
    localparam int unsigned SCREEN_H  = 200;
    localparam int unsigned MAX_DIM   = 4096;
    // random items after the directed part
    localparam int unsigned RANDOM_ITEMS = 600;
    // cycles without any transfer before the run is declared hung
    localparam int unsigned STALL_LIMIT  = 1000;
    // settle time after the last descriptor, pipeline is two stages deep
    localparam int unsigned SETTLE_CYCLES = 16;

    // tracks the blit state, predicts each descriptor and checks the ones that come out
    class blit_tracker;
        int unsigned img_w;
        int unsigned img_h;
        bit          gfx_on;
        logic [7:0]  rows_left;
        logic [7:0]  dest_row;
        logic [11:0] src_row;
        logic [8:0]  row_len;
        logic [8:0]  dest_col;
        logic [11:0] src_col;
        out_item_t   pending_descriptors[$];
        int unsigned mismatches;

        function new();
            img_w = 0;
            img_h = 0;
            gfx_on = 1'b0;
            rows_left = '0;
            dest_row = '0;
            src_row = '0;
            row_len = '0;
            dest_col = '0;
            src_col = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [REG_W-1:0] value);
            case (idx)
                CFG_IMAGE_WIDTH:  img_w = value;
                CFG_IMAGE_HEIGHT: img_h = value;
                CFG_GFX_ENABLE:   gfx_on = value[0];
                default: ;
            endcase
        endfunction

        // part of [start, start+len) that lies inside [0, limit)
        function int unsigned fit_span(int unsigned start, int unsigned len,
                                       int unsigned limit);
            if (start >= limit)
                return 0;
            return (len > limit - start) ? limit - start : len;
        endfunction

        function void note_request(in_item_t req);
            out_item_t   e;
            int unsigned cap_w;
            int unsigned cap_h;
            int unsigned w;
            int unsigned h;
            e = '0;
            cap_w = (img_w > MAX_DIM) ? MAX_DIM : img_w;
            cap_h = (img_h > MAX_DIM) ? MAX_DIM : img_h;
            if (req.action == ACT_START) begin
                rows_left = '0;
                if (!gfx_on) begin
                    e.status = ST_REJECTED;
                end
                else begin
                    w = fit_span(req.src_x, req.copy_width, cap_w);
                    h = fit_span(req.src_y, req.copy_height, cap_h);
                    w = fit_span(req.dest_x, w, SCREEN_W);
                    h = fit_span(req.dest_y, h, SCREEN_H);
                    if (w == 0 || h == 0) begin
                        e.status = ST_EMPTY;
                    end
                    else begin
                        rows_left = 8'(h);
                        dest_row = 8'(req.dest_y);
                        src_row = req.src_y;
                        row_len = 9'(w);
                        dest_col = 9'(req.dest_x);
                        src_col = req.src_x;
                        e.status = ST_ACCEPTED;
                    end
                end
            end
            else if (rows_left == '0) begin
                e.status = ST_IDLE;
            end
            else begin
                e.status = ST_ROW;
                e.dest_offset = 16'(dest_row * SCREEN_W + dest_col);
                e.src_offset = 24'(src_row * cap_w + src_col);
                e.row_length = row_len;
                e.last_row = (rows_left == 8'd1);
                dest_row++;
                src_row++;
                rows_left--;
            end
            pending_descriptors.push_back(e);
        endfunction

        function void report_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
            end
        endfunction

        function void check_descriptor(out_item_t got);
            out_item_t want;
            if (pending_descriptors.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            want = pending_descriptors.pop_front();
            report_field("status", want.status, got.status);
            report_field("dest_offset", want.dest_offset, got.dest_offset);
            report_field("src_offset", want.src_offset, got.src_offset);
            report_field("row_length", want.row_length, got.row_length);
            report_field("last_row", want.last_row, got.last_row);
        endfunction

        function int unsigned outstanding();
            return pending_descriptors.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [REG_W-1:0] cfg_data;

    cbrg_in_if  in_ch ();
    cbrg_out_if out_ch ();

    blit_tracker tracker;
    int unsigned items_issued;
    int unsigned quiet_cycles;
    int unsigned cur_img_w;
    int unsigned cur_img_h;
    // calm flags switch off random gaps for whole stretches
    bit          tx_calm;
    bit          rx_calm;

    clipped_blit_row_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // transfer monitor and watchdog, sampled at the edge before any driver update lands
    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            tracker.note_request(in_ch.data);
        if (out_ch.valid && out_ch.ready)
            tracker.check_descriptor(out_ch.data);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("clipped_blit_row_generator verification failed");
            $finish;
        end
    end

    // descriptor sink: random back-pressure per transfer, with calm stretches
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        rx_calm = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            taken++;
            if (taken % 40 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // one request transfer; valid stays high when the next one follows at once
    task automatic issue(input in_item_t req);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.data <= req;
        in_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_issued++;
    endtask

    // stop sending and wait until every predicted descriptor has come out
    task automatic pause_input();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // back to back writes of all three registers, only while the block is idle
    task automatic program_regs(input int unsigned w, input int unsigned h, input bit en);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data <= REG_W'(w);
        tracker.write_reg(CFG_IMAGE_WIDTH, REG_W'(w));
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data <= REG_W'(h);
        tracker.write_reg(CFG_IMAGE_HEIGHT, REG_W'(h));
        @(posedge clk);
        cfg_index <= CFG_GFX_ENABLE;
        cfg_data <= REG_W'(en);
        tracker.write_reg(CFG_GFX_ENABLE, REG_W'(en));
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_img_w = (w > MAX_DIM) ? MAX_DIM : w;
        cur_img_h = (h > MAX_DIM) ? MAX_DIM : h;
    endtask

    function automatic in_item_t blit_start(int unsigned dx, int unsigned dy,
                                            int unsigned sx, int unsigned sy,
                                            int unsigned cw, int unsigned ch);
        in_item_t req;
        req.action = ACT_START;
        req.dest_x = 16'(dx);
        req.dest_y = 16'(dy);
        req.src_x = 12'(sx);
        req.src_y = 12'(sy);
        req.copy_width = 13'(cw);
        req.copy_height = 13'(ch);
        return req;
    endfunction

    // next-row request, rectangle fields are don't-care and get random bits
    function automatic in_item_t row_request();
        in_item_t req;
        req = blit_start($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        req.action = ACT_NEXT;
        return req;
    endfunction

    // source coordinate mostly inside the image, a little past its edge now and then
    function automatic int unsigned image_coord(int unsigned dim);
        if (dim == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, (dim + 3 > 4095) ? 4095 : dim + 3);
    endfunction

    // mostly plausible rectangles near the screen, some fully random noise
    function automatic in_item_t random_start();
        if ($urandom_range(0, 9) == 0)
            return blit_start($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        return blit_start($urandom_range(0, 339), $urandom_range(0, 209),
                          image_coord(cur_img_w), image_coord(cur_img_h),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(1, 48),
                          ($urandom_range(0, 24) == 0) ? $urandom_range(0, 8191)
                                                       : $urandom_range(1, 6));
    endfunction

    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return SCREEN_W;
            3: return MAX_DIM;
            4: return 8191;
            5: return $urandom_range(0, 8191);
            default: return $urandom_range(2, 400);
        endcase
    endfunction

    initial
    begin
        in_item_t    req;
        int unsigned rows_asked;
        int unsigned next_cfg_at;
        int unsigned random_end;
        tracker = new();
        items_issued = 0;
        quiet_cycles = 0;
        cur_img_w = 0;
        cur_img_h = 0;
        tx_calm = 1'b0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: graphics off rejects, next with nothing pending is idle
        issue(blit_start(0, 0, 0, 0, 4096, 4096));
        issue(row_request());
        pause_input();

        // empty image: nothing to draw
        program_regs(0, 0, 1'b1);
        issue(blit_start(10, 10, 0, 0, 8, 8));
        pause_input();

        // full-size image, request larger than the screen clips to 320 x 200
        program_regs(MAX_DIM, MAX_DIM, 1'b1);
        issue(blit_start(0, 0, 0, 0, 4096, 4096));
        repeat (3) issue(row_request());
        // new start mid-blit drops the pending rows; bottom-right corner gives max offsets
        issue(blit_start(319, 199, 4095, 4095, 1, 1));
        issue(row_request());
        issue(row_request());
        // zero size and starts past the screen edge
        issue(blit_start(5, 5, 5, 5, 0, 7));
        issue(blit_start(5, 5, 5, 5, 7, 0));
        issue(blit_start(320, 0, 0, 0, 10, 10));
        issue(blit_start(0, 200, 0, 0, 10, 10));
        issue(blit_start(65535, 65535, 4095, 4095, 8191, 8191));
        pause_input();

        // oversized image registers act as the cap, clipped on both image and screen
        program_regs(8191, 8191, 1'b1);
        issue(blit_start(300, 190, 10, 4090, 100, 100));
        repeat (2) issue(row_request());
        pause_input();

        // image width changes while rows are still pending
        program_regs(100, 8191, 1'b1);
        repeat (5) issue(row_request());
        pause_input();

        // graphics switched off cancels a pending blit
        program_regs(100, 50, 1'b1);
        issue(blit_start(0, 0, 0, 0, 5, 5));
        pause_input();
        program_regs(100, 50, 1'b0);
        issue(blit_start(0, 0, 0, 0, 5, 5));
        issue(row_request());
        pause_input();

        // random phases, each opened by a fresh register setting while idle
        random_end = items_issued + RANDOM_ITEMS;
        next_cfg_at = items_issued;
        while (items_issued < random_end) begin
            if (items_issued >= next_cfg_at) begin
                pause_input();
                program_regs(pick_dim(), pick_dim(), $urandom_range(0, 7) != 0);
                tx_calm = ($urandom_range(0, 3) == 0);
                next_cfg_at = items_issued + $urandom_range(30, 70);
            end
            if ($urandom_range(0, 19) == 0) begin
                issue(row_request());
            end
            else begin
                req = random_start();
                issue(req);
                // usually ask for every row and maybe one more, sometimes stop short
                if (req.copy_height > 8)
                    rows_asked = ($urandom_range(0, 7) == 0) ? 210 : $urandom_range(0, 10);
                else
                    rows_asked = req.copy_height + $urandom_range(0, 1);
                if ($urandom_range(0, 5) == 0)
                    rows_asked = $urandom_range(0, rows_asked);
                repeat (rows_asked) issue(row_request());
            end
        end

        pause_input();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("clipped_blit_row_generator verification clean");
        else
            $display("clipped_blit_row_generator verification failed");
        $finish;
    end

endmodule

// ----- clipped_blit_row_generator.f -----
rtl/cbrg_pkg.sv
rtl/cbrg_in_if.sv
rtl/cbrg_out_if.sv
rtl/cbrg_clip.sv
rtl/clipped_blit_row_generator.sv
tb/clipped_blit_row_generator_test.sv
